@@ rtl/core/hfe_pkg.sv @@
// Shared types, codes and defaults for the 2-D histogram fill engine.
package hfe_pkg;

   localparam int BIN_CAPACITY_DEF  = 65536;
   localparam int MAX_AXIS_BINS_DEF = 1024;
   localparam int ADDR_MAX_W        = 20;   // covers the largest allowed store
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int WORD_W            = 33;   // filled mark on top of a 32 bit sum
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [1:0] CMD_FILL  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   localparam logic [1:0] ST_BINNED = 2'd0;
   localparam logic [1:0] ST_UNDER  = 2'd1;
   localparam logic [1:0] ST_OVER   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_X_LOW   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_X_HIGH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_LOW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_HIGH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_X_COUNT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_COUNT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_X_SCALE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_SCALE = 3'd7;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] x_coord;
      logic signed [15:0] y_coord;
      logic signed [23:0] weight;
      logic [15:0]        read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         fill_status;
      logic [15:0]        bin_index;
      logic signed [31:0] bin_value;
      logic               bin_filled;
      logic signed [39:0] underflow_total;
      logic signed [39:0] overflow_total;
      logic [31:0]        entry_total;
      logic signed [23:0] weight_min;
      logic signed [23:0] weight_max;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] x_low_edge;
      logic signed [15:0] x_high_edge;
      logic signed [15:0] y_low_edge;
      logic signed [15:0] y_high_edge;
      logic [10:0]        x_bin_count;
      logic [10:0]        y_bin_count;
      logic [31:0]        x_scale;
      logic [31:0]        y_scale;
   } cfg_type;

   typedef enum logic [2:0] {
      OPK_BIN, OPK_UNDER, OPK_OVER, OPK_READ, OPK_CLEAR, OPK_NOP
   } op_kind_type;

   typedef struct packed {
      op_kind_type            kind;
      logic                   addr_ok;
      logic [ADDR_MAX_W-1:0]  addr;
      logic [15:0]            index;
      logic signed [23:0]     weight;
   } op_type;

   typedef enum logic [1:0] {
      FE_IDLE, FE_SCALE, FE_INDEX, FE_PUSH
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_INIT, BE_IDLE, BE_LOAD, BE_DONE, BE_CLEAR
   } be_state_type;

endpackage

@@ rtl/core/hfe_ram.sv @@
// Generic simple dual-port RAM with registered read.
module hfe_ram #(
   parameter int WIDTH = hfe_pkg::WORD_W,
   parameter int DEPTH = hfe_pkg::BIN_CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/hfe_front.sv @@
// Front end: accept a command, range-check the point and work out its bin.
module hfe_front #(
   parameter int BIN_CAPACITY  = hfe_pkg::BIN_CAPACITY_DEF,
   parameter int MAX_AXIS_BINS = hfe_pkg::MAX_AXIS_BINS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  hfe_pkg::cfg_type cfg,
   input  logic             init_busy,
   input  logic             req_valid,
   output logic             req_stall,
   input  hfe_pkg::req_type req_payload,
   output logic             push_valid,
   input  logic             push_ready,
   output hfe_pkg::op_type  push_op
);

   localparam int AXW   = $clog2(MAX_AXIS_BINS);
   localparam int CNTW  = $clog2(MAX_AXIS_BINS + 1);
   localparam int MULW  = AXW + CNTW;
   localparam int SIZEW = 2 * CNTW;

   hfe_pkg::fe_state_type   state_ff, state_in;
   hfe_pkg::req_type        req_ff;
   hfe_pkg::op_kind_type    kind_ff, kind_in;
   logic [31:0]             xprod_ff, yprod_ff;
   logic [SIZEW-1:0]        size_ff;
   logic [AXW-1:0]          xb_ff;
   logic [MULW-1:0]         ymul_ff;
   logic                    read_ok_ff;

   logic [31:0]             xc32, yc32;
   logic [CNTW-1:0]         xc, yc;
   logic signed [16:0]      off_x, off_y;
   logic [47:0]             xprod_full, yprod_full;
   logic [AXW-1:0]          xb_in, yb_in;
   logic [31:0]             idx32;
   logic                    accept;

   // Bin counts: zero acts as one, anything above the axis limit is clipped.
   always_comb begin
      xc32 = (cfg.x_bin_count == 11'd0) ? 32'd1 :
             ((32'(cfg.x_bin_count) > 32'(MAX_AXIS_BINS)) ? 32'(MAX_AXIS_BINS) :
              32'(cfg.x_bin_count));
      yc32 = (cfg.y_bin_count == 11'd0) ? 32'd1 :
             ((32'(cfg.y_bin_count) > 32'(MAX_AXIS_BINS)) ? 32'(MAX_AXIS_BINS) :
              32'(cfg.y_bin_count));
      xc   = xc32[CNTW-1:0];
      yc   = yc32[CNTW-1:0];
   end

   assign off_x      = 17'(req_ff.x_coord) - 17'(cfg.x_low_edge);
   assign off_y      = 17'(req_ff.y_coord) - 17'(cfg.y_low_edge);
   assign xprod_full = 48'(off_x[15:0]) * 48'(cfg.x_scale);
   assign yprod_full = 48'(off_y[15:0]) * 48'(cfg.y_scale);

   always_comb begin
      unique case (req_ff.cmd)
         hfe_pkg::CMD_FILL: begin
            if (req_ff.x_coord < cfg.x_low_edge || req_ff.y_coord < cfg.y_low_edge) begin
               kind_in = hfe_pkg::OPK_UNDER;
            end else if (req_ff.x_coord > cfg.x_high_edge ||
                         req_ff.y_coord > cfg.y_high_edge) begin
               kind_in = hfe_pkg::OPK_OVER;
            end else begin
               kind_in = hfe_pkg::OPK_BIN;
            end
         end
         hfe_pkg::CMD_READ:  kind_in = hfe_pkg::OPK_READ;
         hfe_pkg::CMD_CLEAR: kind_in = hfe_pkg::OPK_CLEAR;
         hfe_pkg::CMD_NOP:   kind_in = hfe_pkg::OPK_NOP;
         default:            kind_in = hfe_pkg::OPK_NOP;
      endcase
   end

   // Clamp each axis into its last bin.
   assign xb_in = (xprod_ff >= 32'(xc)) ? AXW'(xc - CNTW'(1)) : xprod_ff[AXW-1:0];
   assign yb_in = (yprod_ff >= 32'(yc)) ? AXW'(yc - CNTW'(1)) : yprod_ff[AXW-1:0];
   assign idx32 = 32'(xb_ff) + 32'(ymul_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hfe_pkg::FE_IDLE:  if (accept) state_in = hfe_pkg::FE_SCALE;
         hfe_pkg::FE_SCALE: state_in = hfe_pkg::FE_INDEX;
         hfe_pkg::FE_INDEX: state_in = hfe_pkg::FE_PUSH;
         hfe_pkg::FE_PUSH:  if (push_ready) state_in = hfe_pkg::FE_IDLE;
         default:           state_in = hfe_pkg::FE_IDLE;
      endcase
   end

   always_comb begin
      req_stall          = (state_ff != hfe_pkg::FE_IDLE) || init_busy;
      push_valid         = (state_ff == hfe_pkg::FE_PUSH);
      push_op.kind       = kind_ff;
      push_op.weight     = req_ff.weight;
      push_op.addr_ok    = 1'b0;
      push_op.addr       = '0;
      push_op.index      = '0;
      unique case (kind_ff)
         hfe_pkg::OPK_READ: begin
            push_op.addr_ok = read_ok_ff;
            push_op.addr    = hfe_pkg::ADDR_MAX_W'(req_ff.read_index);
            push_op.index   = req_ff.read_index;
         end
         hfe_pkg::OPK_BIN: begin
            push_op.addr_ok = idx32 < 32'(BIN_CAPACITY);
            push_op.addr    = idx32[hfe_pkg::ADDR_MAX_W-1:0];
            push_op.index   = idx32[15:0];
         end
         default: begin
            push_op.addr_ok = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hfe_pkg::FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         req_ff <= req_payload;
      end
      if (state_ff == hfe_pkg::FE_SCALE) begin
         kind_ff  <= kind_in;
         xprod_ff <= xprod_full[47:16];
         yprod_ff <= yprod_full[47:16];
         size_ff  <= SIZEW'(xc) * SIZEW'(yc);
      end
      if (state_ff == hfe_pkg::FE_INDEX) begin
         xb_ff      <= xb_in;
         ymul_ff    <= MULW'(yb_in) * MULW'(xc);
         read_ok_ff <= (32'(req_ff.read_index) < 32'(size_ff)) &&
                       (32'(req_ff.read_index) < 32'(BIN_CAPACITY));
      end
   end

endmodule

@@ rtl/core/hfe_queue.sv @@
// Short queue of classified operations between front and back end.
module hfe_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  hfe_pkg::op_type push_op,
   output logic            pop_valid,
   input  logic            pop_ready,
   output hfe_pkg::op_type pop_op
);

   localparam int PW = $clog2(hfe_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(hfe_pkg::QUEUE_DEPTH + 1);

   hfe_pkg::op_type entry_ff [hfe_pkg::QUEUE_DEPTH];
   logic [PW-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = count_ff != CW'(hfe_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_op     = entry_ff[head_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PW'(hfe_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_ff + PW'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == PW'(hfe_pkg::QUEUE_DEPTH - 1)) ? '0 : head_ff + PW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[tail_ff] <= push_op;
      end
   end

endmodule

@@ rtl/core/hfe_back.sv @@
// Back end: bin store read-modify-write, sums, clear walk and result register.
module hfe_back #(
   parameter int BIN_CAPACITY = hfe_pkg::BIN_CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  hfe_pkg::op_type  pop_op,
   output logic             init_busy,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hfe_pkg::rsp_type rsp_payload
);

   localparam int ADDRW = $clog2(BIN_CAPACITY);
   localparam logic [ADDRW-1:0] LAST_ADDR = ADDRW'(BIN_CAPACITY - 1);

   hfe_pkg::be_state_type  state_ff, state_in;
   hfe_pkg::op_type        op_ff;
   logic [hfe_pkg::WORD_W-1:0] word_ff, rd_data;
   logic [ADDRW-1:0]       ptr_ff, ptr_in;
   logic signed [39:0]     under_ff, under_in, over_ff, over_in;
   logic [31:0]            entry_ff, entry_in;
   logic signed [23:0]     min_ff, min_in, max_ff, max_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   hfe_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   wr_en, rd_en, out_free, finish, start_clear, walking;
   logic [ADDRW-1:0]       wr_addr;
   logic [hfe_pkg::WORD_W-1:0] wr_data;
   logic signed [31:0]     new_val;

   function automatic logic signed [31:0] sat_add32(logic signed [31:0] a,
                                                    logic signed [23:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s[32] != s[31]) begin
         return s[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end
      return s[31:0];
   endfunction

   function automatic logic signed [39:0] sat_add40(logic signed [39:0] a,
                                                    logic signed [23:0] b);
      logic signed [40:0] s;
      s = 41'(a) + 41'(b);
      if (s[40] != s[39]) begin
         return s[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
      end
      return s[39:0];
   endfunction

   hfe_ram #(.WIDTH(hfe_pkg::WORD_W), .DEPTH(BIN_CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (pop_op.addr[ADDRW-1:0]),
      .rd_data (rd_data)
   );

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign walking     = (state_ff == hfe_pkg::BE_INIT) || (state_ff == hfe_pkg::BE_CLEAR);
   assign start_clear = (state_ff == hfe_pkg::BE_IDLE) && pop_valid &&
                        (pop_op.kind == hfe_pkg::OPK_CLEAR);
   assign new_val     = sat_add32(word_ff[31:0], op_ff.weight);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hfe_pkg::BE_INIT: if (ptr_ff == LAST_ADDR) state_in = hfe_pkg::BE_IDLE;
         hfe_pkg::BE_IDLE: begin
            if (pop_valid) begin
               case (pop_op.kind)
                  hfe_pkg::OPK_CLEAR:                  state_in = hfe_pkg::BE_CLEAR;
                  hfe_pkg::OPK_BIN, hfe_pkg::OPK_READ: state_in = hfe_pkg::BE_LOAD;
                  default:                             state_in = hfe_pkg::BE_DONE;
               endcase
            end
         end
         hfe_pkg::BE_LOAD:  state_in = hfe_pkg::BE_DONE;
         hfe_pkg::BE_DONE:  if (out_free) state_in = hfe_pkg::BE_IDLE;
         hfe_pkg::BE_CLEAR: if (ptr_ff == LAST_ADDR) state_in = hfe_pkg::BE_DONE;
         default:           state_in = hfe_pkg::BE_IDLE;
      endcase
   end

   always_comb begin
      init_busy = (state_ff == hfe_pkg::BE_INIT);
      pop_ready = (state_ff == hfe_pkg::BE_IDLE);
      rd_en     = (state_ff == hfe_pkg::BE_IDLE) && pop_valid;
      finish    = (state_ff == hfe_pkg::BE_DONE) && out_free;
      wr_en     = walking ||
                  (finish && op_ff.kind == hfe_pkg::OPK_BIN && op_ff.addr_ok);
      wr_addr   = walking ? ptr_ff : op_ff.addr[ADDRW-1:0];
      wr_data   = walking ? '0 : {1'b1, new_val};
      ptr_in    = walking ? ((ptr_ff == LAST_ADDR) ? '0 : ptr_ff + ADDRW'(1)) : '0;
   end

   // Sums and the result word; totals in the result are those after the step.
   always_comb begin
      under_in = under_ff;
      over_in  = over_ff;
      entry_in = entry_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      rsp_in   = rsp_ff;
      if (start_clear) begin
         under_in = '0;
         over_in  = '0;
         entry_in = '0;
         min_in   = '0;
         max_in   = '0;
      end
      if (finish) begin
         rsp_in.fill_status = hfe_pkg::ST_BINNED;
         rsp_in.bin_index   = '0;
         rsp_in.bin_value   = '0;
         rsp_in.bin_filled  = 1'b0;
         case (op_ff.kind)
            hfe_pkg::OPK_BIN: begin
               rsp_in.bin_index  = op_ff.index;
               rsp_in.bin_value  = op_ff.addr_ok ? new_val : '0;
               rsp_in.bin_filled = op_ff.addr_ok;
               if (op_ff.weight > max_ff) max_in = op_ff.weight;
               if (op_ff.weight < min_ff) min_in = op_ff.weight;
            end
            hfe_pkg::OPK_UNDER: begin
               rsp_in.fill_status = hfe_pkg::ST_UNDER;
               under_in           = sat_add40(under_ff, op_ff.weight);
            end
            hfe_pkg::OPK_OVER: begin
               rsp_in.fill_status = hfe_pkg::ST_OVER;
               over_in            = sat_add40(over_ff, op_ff.weight);
            end
            hfe_pkg::OPK_READ: begin
               rsp_in.bin_index  = op_ff.index;
               rsp_in.bin_value  = op_ff.addr_ok ? word_ff[31:0] : '0;
               rsp_in.bin_filled = op_ff.addr_ok && word_ff[32];
            end
            default: begin
               rsp_in.fill_status = hfe_pkg::ST_BINNED;
            end
         endcase
         if ((op_ff.kind == hfe_pkg::OPK_BIN || op_ff.kind == hfe_pkg::OPK_UNDER ||
              op_ff.kind == hfe_pkg::OPK_OVER) && entry_ff != 32'hFFFF_FFFF) begin
            entry_in = entry_ff + 32'd1;
         end
         rsp_in.underflow_total = under_in;
         rsp_in.overflow_total  = over_in;
         rsp_in.entry_total     = entry_in;
         rsp_in.weight_min      = min_in;
         rsp_in.weight_max      = max_in;
      end
      rsp_valid_in = finish ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hfe_pkg::BE_INIT;
         ptr_ff       <= '0;
         under_ff     <= '0;
         over_ff      <= '0;
         entry_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         under_ff     <= under_in;
         over_ff      <= over_in;
         entry_ff     <= entry_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rd_en) begin
         op_ff <= pop_op;
      end
      if (state_ff == hfe_pkg::BE_LOAD) begin
         word_ff <= rd_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == hfe_pkg::BE_DONE))
      else $error("result raised outside the completion state");

   a_write_only_bins: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !walking) |-> (op_ff.kind == hfe_pkg::OPK_BIN && op_ff.addr_ok))
      else $error("store written for an operation that is not an in-store fill");

   a_entry_monotonic: assert property (@(posedge clock) disable iff (reset)
      !start_clear |=> entry_ff >= $past(entry_ff))
      else $error("entry count went down without a clear");

endmodule

@@ rtl/core/histogram_2d_fill_engine.sv @@
// Top level of the 2-D histogram fill engine: configuration registers and wiring.
//
// Usage: commands enter on req_* (valid/stall) as one transaction each: fill a
// point, read one bin, clear the histogram, or no operation. Every command gives
// exactly one result transaction on rsp_* carrying the bin touched and all sums.
// Configuration is written on csr_* (enable, index, data) while the engine idles.
// Steps: the front end takes a new command only after handing off the last one
// (capture, scale multiply, index multiply, hand-off); the back end takes a fill
// or read through store read, registered data, add and write back, and any other
// command straight to its completion state.
// A clear walks the bin store one entry per cycle and holds the back end until
// the walk ends; commands behind it wait in the two-entry queue.
// After reset the store is swept the same way, and req_stall stays high until
// the sweep ends; configuration writes are taken throughout.
// When the receiver stalls, the result is held in the output register; the back
// end then stops in its completion state and the queue and front end fill up
// before req_stall is raised towards the sender.
module histogram_2d_fill_engine #(
   parameter int BIN_CAPACITY  = hfe_pkg::BIN_CAPACITY_DEF,
   parameter int MAX_AXIS_BINS = hfe_pkg::MAX_AXIS_BINS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [hfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hfe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  hfe_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output hfe_pkg::rsp_type                rsp_payload
);

   hfe_pkg::cfg_type cfg_ff, cfg_in;
   hfe_pkg::op_type  push_op, pop_op;
   logic             push_valid, push_ready, pop_valid, pop_ready, init_busy;

   // Register decode: each write takes the low bits that the register holds.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            hfe_pkg::REG_X_LOW:   cfg_in.x_low_edge  = csr_wdata[15:0];
            hfe_pkg::REG_X_HIGH:  cfg_in.x_high_edge = csr_wdata[15:0];
            hfe_pkg::REG_Y_LOW:   cfg_in.y_low_edge  = csr_wdata[15:0];
            hfe_pkg::REG_Y_HIGH:  cfg_in.y_high_edge = csr_wdata[15:0];
            hfe_pkg::REG_X_COUNT: cfg_in.x_bin_count = csr_wdata[10:0];
            hfe_pkg::REG_Y_COUNT: cfg_in.y_bin_count = csr_wdata[10:0];
            hfe_pkg::REG_X_SCALE: cfg_in.x_scale     = csr_wdata[31:0];
            hfe_pkg::REG_Y_SCALE: cfg_in.y_scale     = csr_wdata[31:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_low_edge  <= 16'sd0;
         cfg_ff.x_high_edge <= 16'sd1023;
         cfg_ff.y_low_edge  <= 16'sd0;
         cfg_ff.y_high_edge <= 16'sd63;
         cfg_ff.x_bin_count <= 11'd1024;
         cfg_ff.y_bin_count <= 11'd64;
         cfg_ff.x_scale     <= 32'd65536;
         cfg_ff.y_scale     <= 32'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify the command and compute the linear bin index.
   hfe_front #(.BIN_CAPACITY(BIN_CAPACITY), .MAX_AXIS_BINS(MAX_AXIS_BINS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .init_busy   (init_busy),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_op     (push_op)
   );

   // Decouple the two halves so a long clear does not hold the sender at once.
   hfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   // Back end: owns the store, the sums and the result register.
   hfe_back #(.BIN_CAPACITY(BIN_CAPACITY)) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_op      (pop_op),
      .init_busy   (init_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the 2-D histogram fill engine.
module tb_top;

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   logic [hfe_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [hfe_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic                            req_valid;
   logic                            req_stall;
   hfe_pkg::req_type                req_payload;
   logic                            rsp_valid;
   logic                            rsp_stall;
   hfe_pkg::rsp_type                rsp_payload;

   histogram_2d_fill_engine dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   // Histogram image kept by the testbench: bins and marks are sparse, an absent
   // key reads as zero, which matches the store after its clearing walk.
   int        hist_bins[int];
   bit        hist_marks[int];
   longint    under_sum, over_sum;
   int unsigned fill_count;
   int        lightest, heaviest;
   hfe_pkg::cfg_type hist_cfg;

   hfe_pkg::rsp_type awaited_results[$];
   int unsigned recent_bins[$];
   int          error_count;
   int          sent_count, seen_count, fill_binned, fill_under, fill_over;
   int          send_idle_pct, rsp_stall_pct;
   int          hold_cycles;

   always #6 clock = ~clock;

   // Hard limit: reset sweep, a handful of clears and every transaction at its
   // slowest, taken several times over.
   initial begin
      #(12 * 3_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic longint clip(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic int unsigned axis_span(logic [10:0] c);
      if (c == 0) return 1;
      return c > hfe_pkg::MAX_AXIS_BINS_DEF ? hfe_pkg::MAX_AXIS_BINS_DEF : c;
   endfunction

   // Scale the offset by the Q16.16 reciprocal width; clamp the high edge into
   // the last bin.
   function automatic int unsigned axis_slot(longint coord, longint low,
                                             logic [31:0] scale, int unsigned count);
      longint unsigned off;
      longint unsigned b;
      off = longint'(coord - low);
      b = (off * {32'd0, scale}) >> 16;
      return b >= count ? count - 1 : int'(b);
   endfunction

   function automatic void wipe_histogram();
      hist_bins.delete();
      hist_marks.delete();
      under_sum = 0;
      over_sum = 0;
      fill_count = 0;
      lightest = 0;
      heaviest = 0;
   endfunction

   // Work out the result of one accepted command and advance the image.
   function automatic hfe_pkg::rsp_type fill_outcome(hfe_pkg::req_type r);
      hfe_pkg::rsp_type o;
      longint      x, y, w;
      int unsigned xc, yc, xb, yb, idx;
      x = longint'($signed(r.x_coord));
      y = longint'($signed(r.y_coord));
      w = longint'($signed(r.weight));
      xc = axis_span(hist_cfg.x_bin_count);
      yc = axis_span(hist_cfg.y_bin_count);
      o = '0;
      o.fill_status = hfe_pkg::ST_BINNED;
      if (r.cmd == hfe_pkg::CMD_FILL) begin
         if (x < $signed(hist_cfg.x_low_edge) || y < $signed(hist_cfg.y_low_edge)) begin
            o.fill_status = hfe_pkg::ST_UNDER;
            under_sum = clip(under_sum + w, 40);
            fill_under++;
         end else if (x > $signed(hist_cfg.x_high_edge) ||
                      y > $signed(hist_cfg.y_high_edge)) begin
            o.fill_status = hfe_pkg::ST_OVER;
            over_sum = clip(over_sum + w, 40);
            fill_over++;
         end else begin
            xb = axis_slot(x, $signed(hist_cfg.x_low_edge), hist_cfg.x_scale, xc);
            yb = axis_slot(y, $signed(hist_cfg.y_low_edge), hist_cfg.y_scale, yc);
            idx = xb + yb * xc;
            o.bin_index = idx[15:0];
            if (idx < hfe_pkg::BIN_CAPACITY_DEF) begin
               hist_bins[idx] = int'(clip(longint'(hist_bins.exists(idx) ?
                                      hist_bins[idx] : 0) + w, 32));
               hist_marks[idx] = 1'b1;
               o.bin_value = hist_bins[idx];
               o.bin_filled = 1'b1;
               recent_bins.push_back(idx);
               if (recent_bins.size() > 64) void'(recent_bins.pop_front());
            end
            if (w > heaviest) heaviest = int'(w);
            if (w < lightest) lightest = int'(w);
            fill_binned++;
         end
         if (fill_count != 32'hFFFF_FFFF) fill_count++;
      end else if (r.cmd == hfe_pkg::CMD_READ) begin
         o.bin_index = r.read_index;
         if (longint'(r.read_index) < longint'(xc) * yc) begin
            if (hist_bins.exists(r.read_index)) o.bin_value = hist_bins[r.read_index];
            if (hist_marks.exists(r.read_index)) o.bin_filled = hist_marks[r.read_index];
         end
      end else if (r.cmd == hfe_pkg::CMD_CLEAR) begin
         wipe_histogram();
      end
      o.underflow_total = under_sum[39:0];
      o.overflow_total  = over_sum[39:0];
      o.entry_total     = fill_count;
      o.weight_min      = lightest[23:0];
      o.weight_max      = heaviest[23:0];
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         error_count++;
         $display("mismatch on result %0d: %s got %h expected %h",
                  seen_count, field, got, want);
      end
   endtask

   // Receiver: stall at random or hold off for a counted stretch; check every
   // transaction taken against the oldest awaited result.
   always @(posedge clock) begin
      hfe_pkg::rsp_type want;
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            error_count++;
            $display("result transaction with nothing awaited");
         end else begin
            want = awaited_results.pop_front();
            report_mismatch("fill_status", rsp_payload.fill_status, want.fill_status);
            report_mismatch("bin_index", rsp_payload.bin_index, want.bin_index);
            report_mismatch("bin_value", rsp_payload.bin_value, want.bin_value);
            report_mismatch("bin_filled", rsp_payload.bin_filled, want.bin_filled);
            report_mismatch("underflow_total", rsp_payload.underflow_total,
                            want.underflow_total);
            report_mismatch("overflow_total", rsp_payload.overflow_total,
                            want.overflow_total);
            report_mismatch("entry_total", rsp_payload.entry_total, want.entry_total);
            report_mismatch("weight_min", rsp_payload.weight_min, want.weight_min);
            report_mismatch("weight_max", rsp_payload.weight_max, want.weight_max);
         end
         seen_count++;
      end
   end

   // Offer one command transaction, idling first at random; predict on accept.
   task automatic send_command(hfe_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      awaited_results.push_back(fill_outcome(r));
      sent_count++;
   endtask

   function automatic hfe_pkg::req_type make_cmd(logic [1:0] c, int x, int y, int w,
                                                 int ri);
      hfe_pkg::req_type r;
      r.cmd = c;
      r.x_coord = x[15:0];
      r.y_coord = y[15:0];
      r.weight = w[23:0];
      r.read_index = ri[15:0];
      return r;
   endfunction

   // Drain all results, let the engine settle, then write every register.
   task automatic write_settings(hfe_pkg::cfg_type c);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= hfe_pkg::REG_X_LOW;
      csr_wdata <= 32'($signed(c.x_low_edge));
      @(posedge clock);
      csr_index <= hfe_pkg::REG_X_HIGH;
      csr_wdata <= 32'($signed(c.x_high_edge));
      @(posedge clock);
      csr_index <= hfe_pkg::REG_Y_LOW;
      csr_wdata <= 32'($signed(c.y_low_edge));
      @(posedge clock);
      csr_index <= hfe_pkg::REG_Y_HIGH;
      csr_wdata <= 32'($signed(c.y_high_edge));
      @(posedge clock);
      csr_index <= hfe_pkg::REG_X_COUNT;
      csr_wdata <= {21'd0, c.x_bin_count};
      @(posedge clock);
      csr_index <= hfe_pkg::REG_Y_COUNT;
      csr_wdata <= {21'd0, c.y_bin_count};
      @(posedge clock);
      csr_index <= hfe_pkg::REG_X_SCALE;
      csr_wdata <= c.x_scale;
      @(posedge clock);
      csr_index <= hfe_pkg::REG_Y_SCALE;
      csr_wdata <= c.y_scale;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hist_cfg = c;
   endtask

   function automatic hfe_pkg::cfg_type make_edges(int xl, int xh, int yl, int yh,
                                                   int xc, int yc, int xs, int ys);
      hfe_pkg::cfg_type c;
      c.x_low_edge = xl[15:0];
      c.x_high_edge = xh[15:0];
      c.y_low_edge = yl[15:0];
      c.y_high_edge = yh[15:0];
      c.x_bin_count = xc[10:0];
      c.y_bin_count = yc[10:0];
      c.x_scale = xs;
      c.y_scale = ys;
      return c;
   endfunction

   // Plausible setting: a random window with scales matched to the bin counts, now and then a random scale.
   function automatic hfe_pkg::cfg_type random_setting();
      int xl, yl, xspan, yspan, xc, yc;
      int unsigned xs, ys;
      xspan = $urandom_range(1, 3000);
      yspan = $urandom_range(1, 3000);
      xl = int'($urandom_range(0, 62000)) - 32768;
      yl = int'($urandom_range(0, 62000)) - 32768;
      xc = $urandom_range(1, 100);
      yc = $urandom_range(1, 100);
      xs = 32'((longint'(xc) << 16) / (xspan + 1) + $urandom_range(0, 3));
      ys = 32'((longint'(yc) << 16) / (yspan + 1) + $urandom_range(0, 3));
      if ($urandom_range(9) == 0) xs = $urandom;
      if ($urandom_range(9) == 0) ys = $urandom;
      return make_edges(xl, xl + xspan, yl, yl + yspan, xc, yc, xs, ys);
   endfunction

   function automatic int pick_coord(logic signed [15:0] lo, logic signed [15:0] hi);
      if (hi >= lo && $urandom_range(99) < 85)
         return int'(lo) + int'($urandom_range(0, int'(hi) - int'(lo)));
      return int'($signed(16'($urandom)));
   endfunction

   function automatic int pick_weight();
      case ($urandom_range(9))
         0:       return 8388607;
         1:       return -8388608;
         default: return int'($signed(24'($urandom)));
      endcase
   endfunction

   // Mostly fills inside the window, reads of bins just filled, some noise.
   function automatic hfe_pkg::req_type random_command();
      int          sel, ri;
      int unsigned cells;
      sel = $urandom_range(99);
      cells = axis_span(hist_cfg.x_bin_count) * axis_span(hist_cfg.y_bin_count);
      if (sel < 70)
         return make_cmd(hfe_pkg::CMD_FILL,
                         pick_coord(hist_cfg.x_low_edge, hist_cfg.x_high_edge),
                         pick_coord(hist_cfg.y_low_edge, hist_cfg.y_high_edge),
                         pick_weight(), $urandom);
      if (sel < 92) begin
         if (recent_bins.size() != 0 && $urandom_range(1))
            ri = recent_bins[$urandom_range(recent_bins.size() - 1)];
         else if ($urandom_range(3) == 0) ri = $urandom_range(65535);
         else ri = $urandom_range(0, (cells > 65536 ? 65536 : cells) - 1);
         return make_cmd(hfe_pkg::CMD_READ, $urandom, $urandom, $urandom, ri);
      end
      return make_cmd(hfe_pkg::CMD_NOP, $urandom, $urandom, $urandom, $urandom);
   endfunction

   task automatic run_random(int count);
      repeat (count) send_command(random_command());
   endtask

   // Corners on the reset setting: low and high edges, both escapes on each axis,
   // extreme weights, reads of the first, last and other bins, no operation and clear.
   task automatic test_directed();
      send_command(make_cmd(hfe_pkg::CMD_FILL, 0, 0, 8388607, 0));
      send_command(make_cmd(hfe_pkg::CMD_FILL, 1023, 63, -8388608, 0));
      send_command(make_cmd(hfe_pkg::CMD_FILL, 1023, 63, 256, 0));
      send_command(make_cmd(hfe_pkg::CMD_FILL, -1, 5, 100, 0));
      send_command(make_cmd(hfe_pkg::CMD_FILL, 5, -32768, -8388608, 0));
      send_command(make_cmd(hfe_pkg::CMD_FILL, 1024, 5, 8388607, 0));
      send_command(make_cmd(hfe_pkg::CMD_FILL, 5, 32767, 77, 0));
      send_command(make_cmd(hfe_pkg::CMD_FILL, 32767, -32768, 1, 0));
      send_command(make_cmd(hfe_pkg::CMD_FILL, 512, 31, -1, 65535));
      send_command(make_cmd(hfe_pkg::CMD_READ, 0, 0, 0, 0));
      send_command(make_cmd(hfe_pkg::CMD_READ, -1, -1, -1, 65535));
      send_command(make_cmd(hfe_pkg::CMD_READ, 0, 0, 0, 31 * 1024 + 512));
      send_command(make_cmd(hfe_pkg::CMD_READ, 0, 0, 0, 12345));
      send_command(make_cmd(hfe_pkg::CMD_NOP, -1, -1, -1, 65535));
      send_command(make_cmd(hfe_pkg::CMD_CLEAR, -1, -1, -1, 65535));
      send_command(make_cmd(hfe_pkg::CMD_READ, 0, 0, 0, 65535));
      send_command(make_cmd(hfe_pkg::CMD_READ, 0, 0, 0, 0));
      send_command(make_cmd(hfe_pkg::CMD_FILL, 3, 3, 5, 0));
   endtask

   // Drive one bin past both ends of its 32 bit range.
   task automatic test_bin_saturation();
      repeat (260) send_command(make_cmd(hfe_pkg::CMD_FILL, 7, 2, 8388607, 0));
      repeat (520) send_command(make_cmd(hfe_pkg::CMD_FILL, 7, 2, -8388608, 0));
      send_command(make_cmd(hfe_pkg::CMD_READ, 0, 0, 0, 2 * 1024 + 7));
   endtask

   // Odd and extreme settings: zero and oversize counts, zero and full scales,
   // full-range edges, indices past the store, reversed edges.
   task automatic test_extreme_settings();
      write_settings(make_edges(-32768, 32767, -32768, 32767, 0, 0, 0, 0));
      run_random(20);
      write_settings(make_edges(-32768, 32767, -32768, 32767, 2047, 2047,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF));
      run_random(40);
      write_settings(make_edges(0, 1023, 0, 1023, 1024, 1024, 65536, 65536));
      run_random(40);
      write_settings(make_edges(100, -100, 50, -50, 8, 8, 65536, 65536));
      run_random(20);
      write_settings(make_edges(-8, 7, -4, 3, 16, 8, 65536, 65536));
      run_random(40);
   endtask

   // Hold the receiver off for a long stretch while commands keep coming, so
   // the queue fills and req_stall reaches the sender.
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_cycles = 400;
      run_random(30);
   endtask

   // Random settings under each idling pattern; clear now and then.
   task automatic test_random_phases();
      int idle_mix[4][2] = '{'{0, 0}, '{72, 0}, '{0, 72}, '{27, 27}};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = 0;
         rsp_stall_pct = 0;
         write_settings(random_setting());
         send_idle_pct = idle_mix[p][0];
         rsp_stall_pct = idle_mix[p][1];
         run_random(120);
         if (p == 1 || p == 3)
            send_command(make_cmd(hfe_pkg::CMD_CLEAR, $urandom, $urandom, $urandom,
                                  $urandom));
         run_random(120);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = hfe_pkg::REG_X_LOW;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      hold_cycles = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      error_count = 0;
      sent_count = 0;
      seen_count = 0;
      fill_binned = 0;
      fill_under = 0;
      fill_over = 0;
      hist_cfg = make_edges(0, 1023, 0, 63, 1024, 64, 65536, 65536);
      wipe_histogram();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_bin_saturation();
      test_extreme_settings();
      test_backpressure();
      test_random_phases();

      // Drain, then allow for the back end to settle.
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      $display("covered %0d commands, %0d results: %0d binned, %0d underflow, %0d overflow",
               sent_count, seen_count, fill_binned, fill_under, fill_over);
      $display("settings: reset, extremes, reversed edges and 4 random idling phases");
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
